>>> rtl/reversible_deque_positional_top_assert.svh
// Assertion macros for the reversible deque block.
// Expects clk and rst to be in scope where a macro is used.
`ifndef REVERSIBLE_DEQUE_POSITIONAL_TOP_ASSERT_SVH
`define REVERSIBLE_DEQUE_POSITIONAL_TOP_ASSERT_SVH

// Condition holds at every edge outside reset.
`define RDP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define RDP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RDP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/rdp_pkg.sv
// Shared types, field widths and codes for the reversible deque block.
// No dependencies; imported by every rdp module.
package rdp_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int W_KIND   = 3;
  localparam int W_INDEX  = 7;
  localparam int W_ITEM   = 32;
  localparam int W_STATUS = 2;
  localparam int W_OCC    = 7;

  localparam logic [W_KIND-1:0] REQ_GET = 3'd0;
  localparam logic [W_KIND-1:0] REQ_INS = 3'd1;
  localparam logic [W_KIND-1:0] REQ_REM = 3'd2;
  localparam logic [W_KIND-1:0] REQ_REV = 3'd3;
  localparam logic [W_KIND-1:0] REQ_CLR = 3'd4;

  localparam logic [W_STATUS-1:0] ST_OK   = 2'd0;
  localparam logic [W_STATUS-1:0] ST_IDX  = 2'd1;
  localparam logic [W_STATUS-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [W_KIND-1:0]  req_type;
    logic [W_INDEX-1:0] item_index;
    logic [W_ITEM-1:0]  item_value;
  } rdp_req_t;

  typedef struct packed {
    logic [W_ITEM-1:0]   read_value;
    logic [W_STATUS-1:0] status;
    logic [W_OCC-1:0]    occupancy;
  } rdp_result_t;

endpackage

>>> rtl/rdp_slot.sv
// Shared slot unit: maps a logical offset (-1 .. DEPTH) from a base slot
// to a physical ring slot, in forward or reversed order. Uses rdp_pkg.
module rdp_slot #(
  parameter int DEPTH = rdp_pkg::DEPTH_DEF
) (
  input  logic [$clog2(DEPTH)-1:0] base,
  input  logic [$clog2(DEPTH+1):0] offset,
  input  logic                     rev,
  output logic [$clog2(DEPTH)-1:0] slot
);
  import rdp_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam int OW = CW + 1;

  logic [CW-1:0]   ofs_u;
  logic [AW-1:0]   m;
  logic [AW+1:0]   sum;

  assign ofs_u = offset[CW-1:0];

  always_comb begin
    // reduce offset modulo DEPTH; negative offsets are only ever -1
    if (offset[OW-1]) begin
      m = AW'(DEPTH - 1);
    end else if (ofs_u >= CW'(DEPTH)) begin
      m = AW'(ofs_u - CW'(DEPTH));
    end else begin
      m = AW'(ofs_u);
    end
    if (rev) begin
      sum = (AW+2)'(base) + (AW+2)'(DEPTH) - (AW+2)'(m);
    end else begin
      sum = (AW+2)'(base) + (AW+2)'(m);
    end
    if (sum >= (AW+2)'(DEPTH)) begin
      slot = AW'(sum - (AW+2)'(DEPTH));
    end else begin
      slot = AW'(sum);
    end
  end

endmodule

>>> rtl/rdp_mem.sv
// Ring storage for the deque: one write port, one read port, registered read.
// Uses rdp_pkg for default sizes.
module rdp_mem #(
  parameter int DEPTH       = rdp_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = rdp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [VALUE_WIDTH-1:0]   wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [VALUE_WIDTH-1:0]   rdata
);
  import rdp_pkg::*;

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/rdp_ctrl.sv
// Request sequencer for the deque: decodes each item, drives the shared slot
// unit and walks the shorter side of the ring one entry a cycle.
// Depends on rdp_pkg, rdp_slot, rdp_mem and the assertion macro header.
`include "reversible_deque_positional_top_assert.svh"
module rdp_ctrl #(
  parameter int DEPTH       = rdp_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = rdp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rdp_pkg::rdp_req_t   req,
  output logic                res_valid,
  input  logic                res_take,
  output rdp_pkg::rdp_result_t res
);
  import rdp_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam int OW = CW + 1;
  localparam int IW = (CW > W_INDEX) ? CW : W_INDEX;
  localparam logic [OW-1:0] OFF_ONE = {{(OW-1){1'b0}}, 1'b1};
  localparam logic [OW-1:0] OFF_NEG = {OW{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_GET_RD, S_RM_RD, S_SETUP, S_MOVE, S_FIN_WR, S_FIN_HEAD, S_DONE
  } state_t;

  state_t                  state;
  logic [AW-1:0]           head;
  logic [CW-1:0]           count;
  logic                    rev;
  logic [W_KIND-1:0]       kind;
  logic [W_INDEX-1:0]      idx_w;
  logic [VALUE_WIDTH-1:0]  val;
  logic [VALUE_WIDTH-1:0]  rd;
  logic [W_STATUS-1:0]     status;
  logic [CW-1:0]           n_left;
  logic                    up;
  logic                    front;
  logic [OW-1:0]           src0;
  logic [AW-1:0]           rptr;
  logic [AW-1:0]           prev;
  logic                    pend;

  logic [IW-1:0]           idx_e;
  logic [IW-1:0]           cnt_e;
  logic [CW-1:0]           idx_c;
  logic [OW-1:0]           idx_off;
  logic [OW-1:0]           cnt_off;
  logic                    back;
  logic [CW-1:0]           n_dec;
  logic [OW-1:0]           src_dec;
  logic [OW-1:0]           offset;
  logic [AW-1:0]           slot;
  logic                    phys_up;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [VALUE_WIDTH-1:0]  mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic [VALUE_WIDTH-1:0]  mem_rdata;

  function automatic logic [AW-1:0] step_slot(input logic [AW-1:0] p, input logic inc);
    if (inc) begin
      return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
    end
    return (p == '0) ? AW'(DEPTH - 1) : AW'(p - 1'b1);
  endfunction

  assign idx_e   = IW'(idx_w);
  assign cnt_e   = IW'(count);
  assign idx_c   = idx_e[CW-1:0];
  assign idx_off = {1'b0, idx_c};
  assign cnt_off = {1'b0, count};
  assign back    = idx_c >= (count >> 1);
  assign phys_up = up ^ rev;

  // moves and first source per shift direction; the write side steps opposite
  always_comb begin
    if (kind == REQ_INS) begin
      n_dec   = back ? CW'(count - idx_c) : idx_c;
      src_dec = back ? cnt_off + OFF_NEG : '0;
    end else begin
      n_dec   = back ? CW'(count - idx_c - 1'b1) : idx_c;
      src_dec = back ? idx_off + OFF_ONE : idx_off + OFF_NEG;
    end
  end

  // one slot lookup per cycle, chosen by the step in hand
  always_comb begin
    case (state)
      S_DECODE:   offset = (kind == REQ_REV) ? cnt_off + OFF_NEG : idx_off;
      S_SETUP:    offset = src0;
      S_FIN_WR:   offset = front ? idx_off + OFF_NEG : idx_off;
      S_FIN_HEAD: offset = (kind == REQ_INS) ? OFF_NEG : OFF_ONE;
      default:    offset = idx_off;
    endcase
  end

  rdp_slot #(.DEPTH(DEPTH)) u_slot (
    .base   (head),
    .offset (offset),
    .rev    (rev),
    .slot   (slot)
  );

  always_comb begin
    mem_raddr = (state == S_MOVE) ? rptr : slot;
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = val;
    if (state == S_MOVE && pend) begin
      mem_we    = 1'b1;
      mem_waddr = step_slot(prev, !phys_up);
      mem_wdata = mem_rdata;
    end else if (state == S_FIN_WR) begin
      mem_we    = 1'b1;
    end
  end

  rdp_mem #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      rev   <= 1'b0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind  <= req.req_type;
            idx_w <= req.item_index;
            val   <= VALUE_WIDTH'(req.item_value);
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          rd     <= '0;
          n_left <= n_dec;
          src0   <= src_dec;
          up     <= (kind == REQ_INS) ^ back;
          front  <= !back;
          case (kind)
            REQ_GET: begin
              if (idx_e >= cnt_e) begin
                status <= ST_IDX;
                state  <= S_DONE;
              end else begin
                status <= ST_OK;
                state  <= S_GET_RD;
              end
            end
            REQ_INS: begin
              if (idx_e > cnt_e) begin
                status <= ST_IDX;
                state  <= S_DONE;
              end else if (count == CW'(DEPTH)) begin
                status <= ST_FULL;
                state  <= S_DONE;
              end else begin
                status <= ST_OK;
                state  <= (n_dec == '0) ? S_FIN_WR : S_SETUP;
              end
            end
            REQ_REM: begin
              if (idx_e >= cnt_e) begin
                status <= ST_IDX;
                state  <= S_DONE;
              end else begin
                status <= ST_OK;
                state  <= S_RM_RD;
              end
            end
            REQ_REV: begin
              status <= ST_OK;
              state  <= S_DONE;
              if (count != '0) begin
                head <= slot;
              end
              rev <= !rev;
            end
            REQ_CLR: begin
              status <= ST_OK;
              state  <= S_DONE;
              head   <= '0;
              count  <= '0;
              rev    <= 1'b0;
            end
            default: begin
              status <= ST_OK;
              state  <= S_DONE;
            end
          endcase
        end
        S_GET_RD: begin
          rd    <= mem_rdata;
          state <= S_DONE;
        end
        S_RM_RD: begin
          rd    <= mem_rdata;
          state <= (n_left == '0) ? S_FIN_HEAD : S_SETUP;
        end
        S_SETUP: begin
          rptr  <= slot;
          pend  <= 1'b0;
          state <= S_MOVE;
        end
        S_MOVE: begin
          // read one entry ahead, write the entry fetched last cycle
          if (n_left != '0) begin
            rptr   <= step_slot(rptr, phys_up);
            prev   <= rptr;
            n_left <= n_left - 1'b1;
            pend   <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= (kind == REQ_INS) ? S_FIN_WR : S_FIN_HEAD;
            end
          end
        end
        S_FIN_WR: begin
          state <= S_FIN_HEAD;
        end
        S_FIN_HEAD: begin
          if (front) begin
            head <= slot;
          end
          count <= (kind == REQ_INS) ? CW'(count + 1'b1) : CW'(count - 1'b1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall       = (state != S_IDLE);
  assign res_valid      = (state == S_DONE);
  assign res.read_value = W_ITEM'(rd);
  assign res.status     = status;
  assign res.occupancy  = W_OCC'(count);

  `RDP_ASSERT_ALWAYS(a_count_bound, count <= CW'(DEPTH), "occupancy beyond capacity")
  `RDP_ASSERT_IMP(a_full, res_valid && status == ST_FULL, count == CW'(DEPTH), "spurious full")
  `RDP_ASSERT_IMP(a_err_zero, res_valid && status != ST_OK, rd == '0, "error with a value")
  `RDP_ASSERT_NXT(a_busy, in_valid && !in_stall, in_stall, "sequencer idle after accept")

endmodule

>>> rtl/reversible_deque_positional_top.sv
// Reversible positional deque: a ring of DEPTH values of VALUE_WIDTH bits.
// Input channel (in_valid/in_stall) takes one request item: req_type selects
// get, insert, remove, reverse or clear at logical position item_index.
// Output channel (out_valid/out_stall) gives one result item per request:
// read_value, status (ok, index out of range, full) and occupancy.
// in_stall is high from the accepting edge until the result has moved into
// the output register, so requests run one at a time.
// Insert and remove shift the entries on the shorter side of the ring, at
// most DEPTH/2 of them, so up to 32 at DEPTH 64; the other kinds and the
// errors shift nothing.
// The shift runs one entry a cycle through the single read and write port
// of the ring memory.
// The output register frees the sequencer while a result waits; a stalled
// result holds, and the next request waits behind it once its own result
// is ready. Synchronous reset empties the deque and restores forward order;
// stored values are not cleared and need no clearing pass.
// Depends on rdp_pkg and rdp_ctrl.
module reversible_deque_positional_top #(
  parameter int DEPTH       = rdp_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = rdp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rdp_pkg::W_KIND-1:0]    req_type,
  input  logic [rdp_pkg::W_INDEX-1:0]   item_index,
  input  logic [rdp_pkg::W_ITEM-1:0]    item_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rdp_pkg::W_ITEM-1:0]    read_value,
  output logic [rdp_pkg::W_STATUS-1:0]  status,
  output logic [rdp_pkg::W_OCC-1:0]     occupancy
);
  import rdp_pkg::*;

  rdp_req_t    req;
  rdp_result_t res;
  logic        res_valid;
  logic        res_take;

  assign req.req_type   = req_type;
  assign req.item_index = item_index;
  assign req.item_value = item_value;

  rdp_ctrl #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // load when the output register is empty or draining this cycle
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      read_value <= res.read_value;
      status     <= res.status;
      occupancy  <= res.occupancy;
    end
  end

endmodule

>>> dv/reversible_deque_positional_top_tb.sv
// Self-checking testbench for reversible_deque_positional_top.
// Drives request items from a backlog queue and checks each result item against
// a predictor of the ring deque. Depends on rdp_pkg and the block's RTL.
module reversible_deque_positional_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rdp_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int TOTAL_ITEMS  = 950;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRINT_CAP    = 40;
  localparam logic [W_KIND-1:0] REQ_UNUSED_HI = '1;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [W_KIND-1:0] req_type = REQ_GET;
  logic [W_INDEX-1:0] item_index = '0;
  logic [W_ITEM-1:0] item_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [W_ITEM-1:0] read_value;
  logic [W_STATUS-1:0] status;
  logic [W_OCC-1:0] occupancy;

  reversible_deque_positional_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .item_index(item_index), .item_value(item_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_value(read_value), .status(status), .occupancy(occupancy)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Predictor state: ring of values, front slot, count and direction.
  logic [W_ITEM-1:0] ring [DEPTH];
  logic [5:0] front_slot = '0;
  int stored = 0;
  logic flipped = 1'b0;

  rdp_req_t req_backlog[$];
  rdp_result_t result_due[$];
  int mismatches = 0;
  int cycles = 0;
  bit req_took = 1'b0;

  // Stimulus planning: shadow occupancy and count of items that do work.
  int plan_occ = 0;
  int planned = 0;

  // Physical slot of logical offset off; negative offsets wrap.
  function automatic logic [5:0] ring_slot(logic [5:0] base, int off);
    logic [5:0] m;
    m = off[5:0];
    return flipped ? base - m : base + m;
  endfunction

  function automatic rdp_result_t deque_apply(rdp_req_t r);
    rdp_result_t res;
    int idx;
    int k;
    idx = r.item_index;
    res.read_value = '0;
    res.status = ST_OK;
    case (r.req_type)
      REQ_GET: begin
        if (idx >= stored) res.status = ST_IDX;
        else res.read_value = ring[ring_slot(front_slot, idx)];
      end
      REQ_INS: begin
        if (idx > stored) begin
          res.status = ST_IDX;
        end else if (stored >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (idx >= stored / 2) begin
            for (k = stored - 1; k >= idx; k--)
              ring[ring_slot(front_slot, k + 1)] = ring[ring_slot(front_slot, k)];
            ring[ring_slot(front_slot, idx)] = r.item_value;
          end else begin
            // shift the front side one slot towards the front, head follows
            for (k = 0; k < idx; k++)
              ring[ring_slot(front_slot, k - 1)] = ring[ring_slot(front_slot, k)];
            ring[ring_slot(front_slot, idx - 1)] = r.item_value;
            front_slot = ring_slot(front_slot, -1);
          end
          stored++;
        end
      end
      REQ_REM: begin
        if (idx >= stored) begin
          res.status = ST_IDX;
        end else begin
          res.read_value = ring[ring_slot(front_slot, idx)];
          if (idx >= stored / 2) begin
            for (k = idx; k + 1 < stored; k++)
              ring[ring_slot(front_slot, k)] = ring[ring_slot(front_slot, k + 1)];
          end else begin
            for (k = idx; k >= 1; k--)
              ring[ring_slot(front_slot, k)] = ring[ring_slot(front_slot, k - 1)];
            front_slot = ring_slot(front_slot, 1);
          end
          stored--;
        end
      end
      REQ_REV: begin
        if (stored > 0) front_slot = ring_slot(front_slot, stored - 1);
        flipped = ~flipped;
      end
      REQ_CLR: begin
        front_slot = '0;
        stored = 0;
        flipped = 1'b0;
      end
      default: ;
    endcase
    res.occupancy = stored[W_OCC-1:0];
    return res;
  endfunction

  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic add_req(logic [W_KIND-1:0] kind, int idx, logic [W_ITEM-1:0] val);
    rdp_req_t r;
    r.req_type = kind;
    r.item_index = idx[W_INDEX-1:0];
    r.item_value = val;
    req_backlog.insert(req_backlog.size(), r);
    // track the occupancy as the block will see it, using the truncated index
    case (kind)
      REQ_INS: if (r.item_index <= plan_occ && plan_occ < DEPTH) plan_occ++;
      REQ_REM: if (r.item_index < plan_occ) plan_occ--;
      REQ_CLR: plan_occ = 0;
      default: ;
    endcase
    if (kind <= REQ_CLR) planned++;
  endtask

  // Position biased towards both ends of the live range [0, hi].
  function automatic int pick_pos(int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 0;
    if (r < 4) return hi;
    return $urandom_range(0, hi);
  endfunction

  task automatic add_mixed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) add_req(REQ_GET, plan_occ > 0 ? pick_pos(plan_occ - 1) : 0, $urandom());
    else if (r < 50) add_req(REQ_INS, pick_pos(plan_occ), $urandom());
    else if (r < 72) add_req(REQ_REM, plan_occ > 0 ? pick_pos(plan_occ - 1) : 0, $urandom());
    else if (r < 80) add_req(REQ_REV, $urandom_range(0, 127), $urandom());
    else if (r < 83) add_req(REQ_CLR, $urandom_range(0, 127), $urandom());
    else if (r < 86)
      add_req(W_KIND'($urandom_range(REQ_CLR + 1, REQ_UNUSED_HI)), $urandom_range(0, 127),
              $urandom());
    else
      add_req(W_KIND'($urandom_range(REQ_GET, REQ_REM)), $urandom_range(plan_occ + 1, 127),
              $urandom());
  endtask

  initial begin : stimulus
    int seg;
    int n;
    int r;
    // empty store corners
    add_req(REQ_GET, 0, 32'h0);
    add_req(REQ_REM, 0, 32'h0);
    add_req(REQ_INS, 1, 32'hDEAD_BEEF);
    add_req(REQ_REV, 0, 32'h0);
    // build a short sequence through both shift sides
    add_req(REQ_INS, 0, 32'h0000_0000);
    add_req(REQ_INS, 1, 32'hFFFF_FFFF);
    add_req(REQ_INS, 0, 32'hA5A5_A5A5);
    add_req(REQ_INS, 2, 32'h5A5A_5A5A);
    add_req(REQ_GET, 0, 32'h0);
    add_req(REQ_GET, 3, 32'h0);
    add_req(REQ_GET, 4, 32'h0);
    add_req(REQ_GET, 127, 32'hFFFF_FFFF);
    add_req(REQ_INS, 127, 32'hFFFF_FFFF);
    add_req(REQ_REV, 0, 32'h0);
    add_req(REQ_GET, 0, 32'h0);
    add_req(REQ_GET, 3, 32'h0);
    add_req(REQ_REM, 1, 32'h0);
    add_req(REQ_REM, 2, 32'h0);
    add_req(REQ_INS, 64, 32'h1);
    add_req(W_KIND'(REQ_CLR + 1), 127, 32'hFFFF_FFFF);
    add_req(W_KIND'(REQ_UNUSED_HI - 1), 0, 32'h0);
    add_req(REQ_UNUSED_HI, 64, 32'h8000_0001);
    add_req(REQ_CLR, 0, 32'h0);
    add_req(REQ_GET, 0, 32'h0);
    add_req(REQ_REV, 0, 32'h0);
    add_req(REQ_INS, 0, 32'h1234_5678);

    while (planned < TOTAL_ITEMS) begin
      seg = $urandom_range(0, 9);
      if (seg < 3) begin
        // fill to full, then push against the full store
        while (plan_occ < DEPTH) begin
          r = $urandom_range(0, 99);
          if (r < 80) add_req(REQ_INS, pick_pos(plan_occ), $urandom());
          else if (r < 92) add_req(REQ_GET, pick_pos(plan_occ - 1), $urandom());
          else if (r < 96) add_req(REQ_REV, 0, $urandom());
          else add_req(REQ_REM, pick_pos(plan_occ - 1), $urandom());
        end
        n = $urandom_range(1, 3);
        repeat (n) add_req(REQ_INS, $urandom_range(0, DEPTH), $urandom());
        add_req(REQ_GET, DEPTH - 1, $urandom());
      end else if (seg < 5) begin
        // drain to empty, then one get, insert or remove at position 0
        while (plan_occ > 0) begin
          r = $urandom_range(0, 99);
          if (r < 80) add_req(REQ_REM, pick_pos(plan_occ - 1), $urandom());
          else if (r < 92) add_req(REQ_GET, pick_pos(plan_occ - 1), $urandom());
          else if (r < 96) add_req(REQ_REV, 0, $urandom());
          else add_req(REQ_INS, pick_pos(plan_occ), $urandom());
        end
        add_req(W_KIND'($urandom_range(REQ_GET, REQ_REM)), 0, $urandom());
      end else begin
        n = $urandom_range(10, 60);
        repeat (n) add_mixed();
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (req_backlog.size() != 0 || in_valid || result_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Request driver: bursts of items separated by idle gaps.
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin : drive_requests
    rdp_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_took) begin
      if (gap_left > 0 || req_backlog.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        nxt = req_backlog[0];
        req_backlog.delete(0);
        in_valid <= 1'b1;
        req_type <= nxt.req_type;
        item_index <= nxt.item_index;
        item_value <= nxt.item_value;
        if (burst_left <= 1) begin
          // long gap-free stretches now and then
          if ($urandom_range(0, 9) < 3) begin
            burst_left = $urandom_range(20, 60);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = $urandom_range(1, 8);
          end
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Result receiver: stall pattern switches between modes.
  int stall_mode = 0;
  int mode_left = 50;

  always @(negedge clk) begin : drive_stall
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 4);
        2: out_stall <= ~out_stall;
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
      if (mode_left <= 1) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 150);
      end else begin
        mode_left--;
      end
    end
  end

  always @(posedge clk) begin : monitor
    rdp_req_t seen;
    rdp_result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      req_took = !rst && in_valid && !in_stall;
      if (!rst && out_valid && !out_stall) begin
        if (result_due.size() == 0) begin
          log_mismatch("result item with no request outstanding");
        end else begin
          want = result_due[0];
          result_due.delete(0);
          if (read_value !== want.read_value)
            log_mismatch($sformatf("read_value %h, expected %h", read_value, want.read_value));
          if (status !== want.status)
            log_mismatch($sformatf("status %0d, expected %0d", status, want.status));
          if (occupancy !== want.occupancy)
            log_mismatch($sformatf("occupancy %0d, expected %0d", occupancy, want.occupancy));
        end
      end
      if (req_took) begin
        seen.req_type = req_type;
        seen.item_index = item_index;
        seen.item_value = item_value;
        result_due.insert(result_due.size(), deque_apply(seen));
      end
    end
  end

endmodule
